// ===== rtl/rif_pkg.sv =====
package rif_pkg;

    localparam int VALUE_W        = 32;
    localparam int BASE_W         = 6;
    localparam int SPEC_W         = 7;
    localparam int FLAGS_W        = 7;
    localparam int CHAR_W         = 8;
    localparam int CNT_W          = 6;
    localparam int DEF_MAX_DIGITS = 32;
    localparam int DEF_MAX_FIELD  = 60;

    // quotient bits retired per cycle by the divide unit
    localparam int BITS_PER_STEP  = 8;
    localparam int DIV_STEPS      = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_OCT = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

    // format flag bit positions
    localparam int FL_SIGNED = 0;
    localparam int FL_LEFT   = 1;
    localparam int FL_PLUS   = 2;
    localparam int FL_BLANK  = 3;
    localparam int FL_ALT    = 4;
    localparam int FL_ZERO   = 5;
    localparam int FL_LOWER  = 6;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    localparam logic [BASE_W-1:0] TEN = BASE_W'(10);

    // digit value 0..35 to ascii
    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [BASE_W-1:0] v,
        input logic              lower
    );
        logic [CHAR_W-1:0] ch;
        if (v < TEN) begin
            ch = CH_ZERO + CHAR_W'(v);
        end else if (lower) begin
            ch = CH_LO_A + CHAR_W'(v - TEN);
        end else begin
            ch = CH_UP_A + CHAR_W'(v - TEN);
        end
        return ch;
    endfunction

endpackage

// ===== rtl/radix_integer_formatter.sv =====
// Integer to text formatter in the manner of a printf integer conversion.
// A request is taken when start is high and busy is low; it carries a
// 32-bit value, a radix of 2 to 36, a field width, a precision and flags.
// The block then streams the formatted field out one ASCII character per
// cycle on o_char_out, each marked by a one-cycle o_strobe, with o_last on
// the final character. The receiver cannot stall this stream: every
// strobed character must be taken in the cycle it appears. A radix outside
// 2..36 gives a single strobe with o_bad_base high, o_last high and a zero
// character, in the cycle after the request is taken. For a valid radix a
// request runs in order through a digit loop, length arithmetic, stream
// set-up and the emission of the field (at most 63 characters). The digit
// loop runs a shared divide-by-radix unit that retires 8 quotient bits per
// cycle and yields one digit each pass over the value. The worst case is
// radix 2 with a full 32-bit magnitude and a wide field. busy is high for
// the whole of the request and no request is taken meanwhile.
module radix_integer_formatter #(
    parameter int MAX_DIGITS = rif_pkg::DEF_MAX_DIGITS,
    parameter int MAX_FIELD  = rif_pkg::DEF_MAX_FIELD
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rif_pkg::VALUE_W-1:0]       i_value,
    input  logic [rif_pkg::BASE_W-1:0]        i_base,
    input  logic signed [rif_pkg::SPEC_W-1:0] i_field_width,
    input  logic signed [rif_pkg::SPEC_W-1:0] i_precision,
    input  logic [rif_pkg::FLAGS_W-1:0]       i_format_flags,
    output logic                              o_strobe,
    output logic [rif_pkg::CHAR_W-1:0]        o_char_out,
    output logic                              o_last,
    output logic                              o_bad_base
);
    import rif_pkg::*;

    localparam int DIG_AW = $clog2(MAX_DIGITS);
    localparam int ND_W   = $clog2(MAX_DIGITS + 1);
    localparam int NSEG   = 6;

    // top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_PREP,
        ST_LOAD,
        ST_EMIT
    } t_state;

    // segments of the field, in output order
    typedef enum logic [2:0] {
        SG_LPAD,
        SG_SIGN,
        SG_PFX,
        SG_ZERO,
        SG_DIG,
        SG_TPAD
    } t_seg;

    t_state                r_state;
    t_seg                  r_seg;
    logic [CNT_W-1:0]      r_cnt;

    // request fields and divide working state for one conversion
    logic [VALUE_W-1:0]    r_quot;
    logic [BASE_W-1:0]     r_rem;
    logic [STEP_W-1:0]     r_step;
    logic [BASE_W-1:0]     r_base;
    logic [FLAGS_W-1:0]    r_flags;
    logic [CNT_W-1:0]      r_width;
    logic [CNT_W-1:0]      r_prec;
    logic [CHAR_W-1:0]     r_sign_ch;
    logic [ND_W-1:0]       r_nd;

    // segment lengths, settled in the prep cycle
    logic [CNT_W-1:0]      r_lpad;
    logic [CNT_W-1:0]      r_tpad;
    logic [CNT_W-1:0]      r_zero;
    logic [CNT_W-1:0]      r_pfx;

    // digit store, least significant digit first
    logic [BASE_W-1:0]     r_mem [MAX_DIGITS];
    logic [BASE_W-1:0]     r_rd;

    logic                  accept;
    logic                  base_bad;
    logic [SPEC_W-1:0]     fw_abs;
    logic [CNT_W-1:0]      fw_sat;
    logic [CNT_W-1:0]      pr_sat;
    logic [VALUE_W-1:0]    mag;
    logic [CHAR_W-1:0]     sign_ch;

    logic [BASE_W-1:0]     n_rem;
    logic [VALUE_W-1:0]    n_quot;

    logic [CNT_W-1:0]      prec_eff;
    logic [CNT_W-1:0]      pfx_len;
    logic signed [CNT_W+1:0] w_rem;
    logic [CNT_W-1:0]      pad_len;

    logic [CNT_W-1:0]      seg_len [NSEG];
    logic [2:0]            from_idx;
    logic                  seg_any;
    t_seg                  seg_nxt;
    t_seg                  n_seg;
    logic [CNT_W-1:0]      n_cnt;
    logic [DIG_AW-1:0]     rd_idx;
    logic                  seg_end;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // request decode
    always_comb begin
        base_bad = (i_base < BASE_MIN) || (i_base > BASE_MAX);
        fw_abs   = i_field_width[SPEC_W-1] ? SPEC_W'(-i_field_width)
                                           : SPEC_W'(i_field_width);
        fw_sat   = (fw_abs > SPEC_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                 : CNT_W'(fw_abs);
        if (i_precision[SPEC_W-1]) begin
            pr_sat = '0;
        end else if (SPEC_W'(i_precision) > SPEC_W'(MAX_FIELD)) begin
            pr_sat = CNT_W'(MAX_FIELD);
        end else begin
            pr_sat = CNT_W'(i_precision);
        end
        mag     = i_value;
        sign_ch = CH_NUL;
        priority if (i_format_flags[FL_SIGNED] && i_value[VALUE_W-1]) begin
            mag     = VALUE_W'(0) - i_value;
            sign_ch = CH_MINUS;
        end else if (i_format_flags[FL_PLUS]) begin
            sign_ch = CH_PLUS;
        end else if (i_format_flags[FL_BLANK]) begin
            sign_ch = CH_SPACE;
        end
    end

    // shared divide unit: one byte of the dividend per cycle
    always_comb begin
        logic [BASE_W:0]             t;
        logic [BASE_W-1:0]           r;
        logic [BITS_PER_STEP-1:0]    qb;
        logic [BITS_PER_STEP-1:0]    chunk;
        r     = r_rem;
        qb    = '0;
        chunk = r_quot[VALUE_W-1 -: BITS_PER_STEP];
        for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
            t = {r, chunk[i]};
            if (t >= {1'b0, r_base}) begin
                qb[i] = 1'b1;
                t     = t - {1'b0, r_base};
            end
            r = t[BASE_W-1:0];
        end
        n_rem  = r;
        n_quot = {r_quot[VALUE_W-BITS_PER_STEP-1:0], qb};
    end

    // field length arithmetic
    always_comb begin
        prec_eff = (r_prec > CNT_W'(r_nd)) ? r_prec : CNT_W'(r_nd);
        if (!r_flags[FL_ALT]) begin
            pfx_len = '0;
        end else if (r_base == BASE_HEX) begin
            pfx_len = CNT_W'(2);
        end else if (r_base == BASE_OCT) begin
            pfx_len = CNT_W'(1);
        end else begin
            pfx_len = '0;
        end
        w_rem = $signed({2'b00, r_width})
              - $signed({{(CNT_W+1){1'b0}}, (r_sign_ch != CH_NUL)})
              - $signed({2'b00, pfx_len})
              - $signed({2'b00, prec_eff});
        pad_len = (w_rem > 0) ? CNT_W'(w_rem) : '0;
    end

    // next non-empty segment
    always_comb begin
        seg_len[SG_LPAD] = r_lpad;
        seg_len[SG_SIGN] = CNT_W'(r_sign_ch != CH_NUL);
        seg_len[SG_PFX]  = r_pfx;
        seg_len[SG_ZERO] = r_zero;
        seg_len[SG_DIG]  = CNT_W'(r_nd);
        seg_len[SG_TPAD] = r_tpad;
        from_idx = (r_state == ST_LOAD) ? 3'd0 : 3'(r_seg) + 3'd1;
        seg_any  = 1'b0;
        seg_nxt  = SG_LPAD;
        for (int i = NSEG - 1; i >= 0; i--) begin
            if ((3'(i) >= from_idx) && (seg_len[i] != '0)) begin
                seg_any = 1'b1;
                seg_nxt = t_seg'(i);
            end
        end
    end

    // emit stepping and digit read address
    always_comb begin
        seg_end = (r_cnt == CNT_W'(1));
        n_seg   = r_seg;
        n_cnt   = r_cnt;
        if (r_state == ST_LOAD || (r_state == ST_EMIT && seg_end)) begin
            n_seg = seg_nxt;
            n_cnt = seg_len[seg_nxt];
        end else if (r_state == ST_EMIT) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
        rd_idx = (n_seg == SG_DIG) ? DIG_AW'(n_cnt - CNT_W'(1)) : '0;
    end

    // digit store
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && r_step == STEP_W'(DIV_STEPS - 1)) begin
            r_mem[r_nd[DIG_AW-1:0]] <= n_rem;
        end
        r_rd <= r_mem[rd_idx];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= base_bad ? ST_ERR : ST_DIV;
                    end
                end
                ST_ERR: begin
                    r_state <= ST_IDLE;
                end
                ST_DIV: begin
                    if (r_step == STEP_W'(DIV_STEPS - 1) && n_quot == '0) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state <= seg_any ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (seg_end && !seg_any) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_quot    <= mag;
            r_rem     <= '0;
            r_step    <= '0;
            r_nd      <= '0;
            r_base    <= i_base;
            r_flags   <= i_format_flags;
            r_width   <= fw_sat;
            r_prec    <= pr_sat;
            r_sign_ch <= sign_ch;
        end else if (r_state == ST_DIV) begin
            r_quot <= n_quot;
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                // digit done, restart the unit on the quotient
                r_rem  <= '0;
                r_step <= '0;
                r_nd   <= r_nd + ND_W'(1);
            end else begin
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
            end
        end
        if (r_state == ST_PREP) begin
            r_pfx  <= pfx_len;
            r_zero <= prec_eff - CNT_W'(r_nd);
            r_lpad <= r_flags[FL_LEFT] ? '0 : pad_len;
            r_tpad <= r_flags[FL_LEFT] ? pad_len : '0;
        end
        r_seg <= n_seg;
        r_cnt <= n_cnt;
    end

    // character select
    always_comb begin
        o_char_out = CH_NUL;
        if (r_state == ST_EMIT) begin
            unique case (r_seg)
                SG_LPAD: o_char_out = r_flags[FL_ZERO] ? CH_ZERO : CH_SPACE;
                SG_SIGN: o_char_out = r_sign_ch;
                SG_PFX: begin
                    if (seg_end && r_base == BASE_HEX) begin
                        o_char_out = r_flags[FL_LOWER] ? CH_LO_X : CH_UP_X;
                    end else begin
                        o_char_out = CH_ZERO;
                    end
                end
                SG_ZERO: o_char_out = CH_ZERO;
                SG_DIG:  o_char_out = digit_char(r_rd, r_flags[FL_LOWER]);
                SG_TPAD: o_char_out = CH_SPACE;
                default: o_char_out = CH_NUL;
            endcase
        end
    end

    assign o_strobe   = (r_state == ST_EMIT) || (r_state == ST_ERR);
    assign o_bad_base = (r_state == ST_ERR);
    assign o_last     = (r_state == ST_ERR) ||
                        ((r_state == ST_EMIT) && seg_end && !seg_any);

endmodule

// ===== sim/radix_integer_formatter_tb.sv =====
`timescale 1ns / 100ps

module radix_integer_formatter_tb;
    import rif_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 105;
    localparam int FIELD_LIMIT  = 60;   // width and precision saturate here
    localparam int FIELD_CAP    = 63;   // longest field the block emits
    localparam int DRAIN_CYCLES = 200;  // idle run after the last expected character
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 40;

    localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1) << FL_SIGNED;
    localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1) << FL_LEFT;
    localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1) << FL_PLUS;
    localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1) << FL_BLANK;
    localparam logic [FLAGS_W-1:0] F_ALT    = FLAGS_W'(1) << FL_ALT;
    localparam logic [FLAGS_W-1:0] F_ZERO   = FLAGS_W'(1) << FL_ZERO;
    localparam logic [FLAGS_W-1:0] F_LOWER  = FLAGS_W'(1) << FL_LOWER;

    localparam string UPPER_DIGITS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string LOWER_DIGITS = "0123456789abcdefghijklmnopqrstuvwxyz";
    localparam int    X_INDEX      = 33;   // 'x' / 'X' in the digit tables

    typedef struct {
        logic [VALUE_W-1:0]       value;
        logic [BASE_W-1:0]        base;
        logic signed [SPEC_W-1:0] fwidth;
        logic signed [SPEC_W-1:0] prec;
        logic [FLAGS_W-1:0]       flags;
        bit                       hold;   // wait for the block to drain first
    } fmt_req_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } fmt_char_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [VALUE_W-1:0]         i_value = '0;
    logic [BASE_W-1:0]          i_base = '0;
    logic signed [SPEC_W-1:0]   i_field_width = '0;
    logic signed [SPEC_W-1:0]   i_precision = '0;
    logic [FLAGS_W-1:0]         i_format_flags = '0;
    logic                       o_strobe;
    logic [CHAR_W-1:0]          o_char_out;
    logic                       o_last;
    logic                       o_bad_base;

    fmt_req_t  pending_req_q[$];
    fmt_char_t char_expect_q[$];

    int issued_cnt = 0;   // requests raised by the driver
    int taken_cnt  = 0;   // requests accepted by the block
    int err_cnt    = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left   = 0;

    radix_integer_formatter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_base         (i_base),
        .i_field_width  (i_field_width),
        .i_precision    (i_precision),
        .i_format_flags (i_format_flags),
        .o_strobe       (o_strobe),
        .o_char_out     (o_char_out),
        .o_last         (o_last),
        .o_bad_base     (o_bad_base)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_REPORTS) begin
            $display("%0t ERROR %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    // works out the characters of one field and queues them in emission order
    function automatic void format_field(input fmt_req_t r);
        string              digits;
        byte                rev[$];
        byte                fld[$];
        logic [VALUE_W-1:0] mag;
        int                 w;
        int                 p;
        int                 nd;
        int                 n;
        byte                sgn;
        fmt_char_t          e;

        if (r.base < BASE_MIN || r.base > BASE_MAX) begin
            // bad radix: a single flagged nul, nothing else
            e.ch = CH_NUL;
            e.last = 1'b1;
            e.bad = 1'b1;
            char_expect_q.push_back(e);
            return;
        end
        digits = r.flags[FL_LOWER] ? LOWER_DIGITS : UPPER_DIGITS;

        // width uses its magnitude, negative precision means none
        w = r.fwidth;
        p = r.prec;
        if (w < 0) w = -w;
        if (w > FIELD_LIMIT) w = FIELD_LIMIT;
        if (p < 0) p = 0;
        if (p > FIELD_LIMIT) p = FIELD_LIMIT;

        mag = r.value;
        sgn = 0;
        if (r.flags[FL_SIGNED] && mag[VALUE_W-1]) begin
            sgn = CH_MINUS;
            mag = ~mag + 1'b1;   // most negative value stays 2^31, read unsigned
        end else if (r.flags[FL_PLUS]) begin
            sgn = CH_PLUS;
        end else if (r.flags[FL_BLANK]) begin
            sgn = CH_SPACE;
        end
        if (sgn != 0) w--;
        if (r.flags[FL_ALT]) begin
            if (r.base == BASE_HEX) w -= 2;
            else if (r.base == BASE_OCT) w--;
        end

        // digits least significant first; zero always yields one digit
        if (mag == '0) begin
            rev.push_back(CH_ZERO);
        end else begin
            while (mag != '0) begin
                rev.push_back(digits[int'(mag % r.base)]);
                mag = mag / r.base;
            end
        end
        nd = rev.size();
        if (nd > p) p = nd;
        w -= p;

        if (!r.flags[FL_LEFT]) begin
            while (w > 0) begin
                fld.push_back(r.flags[FL_ZERO] ? CH_ZERO : CH_SPACE);
                w--;
            end
        end
        if (sgn != 0) fld.push_back(sgn);
        if (r.flags[FL_ALT]) begin
            if (r.base == BASE_OCT) begin
                fld.push_back(CH_ZERO);
            end else if (r.base == BASE_HEX) begin
                fld.push_back(CH_ZERO);
                fld.push_back(digits[X_INDEX]);
            end
        end
        for (int k = nd; k < p; k++) fld.push_back(CH_ZERO);
        for (int k = nd - 1; k >= 0; k--) fld.push_back(rev[k]);
        // left justify pads with spaces whatever the zero flag says
        while (w > 0) begin
            fld.push_back(CH_SPACE);
            w--;
        end

        n = (fld.size() > FIELD_CAP) ? FIELD_CAP : fld.size();
        for (int k = 0; k < n; k++) begin
            e.ch = fld[k];
            e.last = (k == n - 1);
            e.bad = 1'b0;
            char_expect_q.push_back(e);
        end
    endfunction

    function automatic void push_req(input logic [VALUE_W-1:0] value,
                                     input logic [BASE_W-1:0] base,
                                     input int fwidth, input int prec,
                                     input logic [FLAGS_W-1:0] flags,
                                     input bit hold);
        fmt_req_t r;
        r.value = value;
        r.base = base;
        r.fwidth = SPEC_W'(fwidth);
        r.prec = SPEC_W'(prec);
        r.flags = flags;
        r.hold = hold;
        pending_req_q.push_back(r);
    endfunction

    // mostly valid radices and modest sizes, with corner values mixed in
    function automatic void push_random_req(input bit hold);
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
        int                 fwidth;
        int                 prec;

        case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = 32'h8000_0000;
            2:       value = VALUE_W'($urandom_range(0, 40));
            3:       value = 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 40));
            default: value = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       base = BASE_W'($urandom_range(0, 63));
            1:       base = BASE_HEX;
            2:       base = BASE_OCT;
            3:       base = TEN;
            default: base = BASE_W'($urandom_range(2, 36));
        endcase
        case ($urandom_range(0, 7))
            0:       fwidth = int'($urandom_range(0, 127)) - 64;
            default: fwidth = int'($urandom_range(0, 24)) - 12;
        endcase
        case ($urandom_range(0, 7))
            0:       prec = int'($urandom_range(0, 127)) - 64;
            1, 2:    prec = -1;
            default: prec = int'($urandom_range(0, 12));
        endcase
        push_req(value, base, fwidth, prec, FLAGS_W'($urandom_range(0, 127)), hold);
    endfunction

    // driver: a new request goes out once the previous one has been taken
    always @(negedge i_clk) begin
        fmt_req_t nxt;
        if (i_rst_n && (!start || taken_cnt == issued_cnt)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_req_q.size() == 0) begin
                start <= 1'b0;
            end else if (pending_req_q[0].hold && char_expect_q.size() != 0) begin
                start <= 1'b0;   // sender holds off until the block has drained
            end else begin
                nxt = pending_req_q.pop_front();
                i_value <= nxt.value;
                i_base <= nxt.base;
                i_field_width <= nxt.fwidth;
                i_precision <= nxt.prec;
                i_format_flags <= nxt.flags;
                start <= 1'b1;
                issued_cnt <= issued_cnt + 1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    // end of burst: pick the next burst and the gap before it
                    burst_left <= $urandom_range(1, 12);
                    case ($urandom_range(0, 7))
                        0, 1:    gap_left <= 0;
                        2:       gap_left <= $urandom_range(21, 150);
                        default: gap_left <= $urandom_range(1, 20);
                    endcase
                end
            end
        end
    end

    // monitor: checks each strobed character and predicts accepted requests
    always @(posedge i_clk) begin
        fmt_char_t exp_c;
        fmt_req_t  seen;
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                if (char_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %h last %b bad %b",
                                              o_char_out, o_last, o_bad_base));
                end else begin
                    exp_c = char_expect_q.pop_front();
                    if (o_strobe !== 1'b1 || o_char_out !== exp_c.ch ||
                        o_last !== exp_c.last || o_bad_base !== exp_c.bad) begin
                        report_mismatch($sformatf(
                            "got char %h last %b bad %b, wanted %h %b %b",
                            o_char_out, o_last, o_bad_base,
                            exp_c.ch, exp_c.last, exp_c.bad));
                    end
                end
            end
            if (start && busy === 1'b0) begin
                seen.value = i_value;
                seen.base = i_base;
                seen.fwidth = i_field_width;
                seen.prec = i_precision;
                seen.flags = i_format_flags;
                seen.hold = 1'b0;
                format_field(seen);
                taken_cnt <= taken_cnt + 1;
            end
            // watchdog: a run of cycles with neither a request nor a character
            if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t ERROR watchdog expired", $realtime);
                $display("radix_integer_formatter: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        // directed: zero, extremes, signs, prefixes, saturation, bad radices
        push_req(32'd0,          TEN,        0,   0, '0, 1'b0);
        push_req(32'd0,          TEN,        0,  -1, F_PLUS, 1'b0);
        push_req(32'hFFFF_FFFF,  BASE_MIN,   0,  -1, '0, 1'b0);
        push_req(32'h8000_0000,  TEN,        0,  -1, F_SIGNED, 1'b0);
        push_req(32'h8000_0000,  BASE_HEX,   0,  -1, F_SIGNED | F_ALT, 1'b0);
        push_req(32'hFFFF_FFFF,  TEN,        6,  -1, F_SIGNED, 1'b0);
        push_req(32'd123,        TEN,        0,  -1, F_PLUS | F_SPACE, 1'b0);
        push_req(32'd123,        TEN,        0,  -1, F_SPACE, 1'b0);
        push_req(32'hBEEF,       BASE_HEX,  10,  -1, F_ALT | F_ZERO | F_LOWER, 1'b0);
        push_req(32'hBEEF,       BASE_HEX, -10,  -1, F_ALT | F_LEFT | F_ZERO, 1'b0);
        push_req(32'd8,          BASE_OCT,   6,  -1, F_ALT, 1'b0);
        push_req(32'd0,          BASE_OCT,   4,  -1, F_ALT | F_ZERO, 1'b0);
        push_req(32'd255,        TEN,        6,  -1, F_ALT, 1'b0);
        push_req(32'hFFFF_FFFF,  BASE_MAX,   0,  -1, F_LOWER, 1'b0);
        push_req(32'hFFFF_FFFF,  BASE_MAX,   0,  -1, '0, 1'b0);
        push_req(32'd5,          TEN,       12,   8, F_SPACE, 1'b0);
        push_req(32'd5,          TEN,      -12,   8, F_LEFT | F_PLUS, 1'b0);
        push_req(32'd77,         BASE_W'(0), 0,  -1, '0, 1'b0);
        push_req(32'd77,         BASE_W'(1), 5,   3, F_PLUS, 1'b0);
        push_req(32'd77,         BASE_MAX + BASE_W'(1), 0, -1, '0, 1'b0);
        push_req(32'd77,         BASE_W'(63), 0, -1, F_ALT, 1'b0);
        // longest field: saturated width and precision plus sign and 0x
        push_req(32'hFFFF_FFFF,  BASE_HEX, -64,  63, F_PLUS | F_ALT, 1'b0);
        push_req(32'd1,          BASE_MIN,  63, -64, F_SPACE | F_ZERO, 1'b0);
        push_req(32'h7FFF_FFFF,  BASE_W'(3), -60, 60, F_SIGNED | F_PLUS | F_LEFT, 1'b0);
        push_req(32'hFFFF_FFFF,  BASE_MIN,  60,  40, '0, 1'b0);

        // random part; the first one waits for the directed results to drain
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            push_random_req(i == 0 || $urandom_range(0, 24) == 0);
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_req_q.size() != 0 || taken_cnt != issued_cnt) @(posedge i_clk);
        while (char_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("radix_integer_formatter: match");
        end else begin
            $display("radix_integer_formatter: mismatch");
        end
        $finish;
    end

endmodule
